/* rtl/mslw_pkg.sv */
// Package for the multi-channel weight slew unit.
// Holds field widths, register codes, reset values, shared types and the state enum.
// No dependencies.
package mslw_pkg;

    // Default values for the top-level parameters.
    localparam int unsigned LAYERS_DEF        = 8;
    localparam int unsigned DELTAS_DEF        = 32;
    localparam int unsigned PENDING_DEPTH_DEF = 16;

    // Field widths fixed by the interface.
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned LAYER_W    = 3;
    localparam int unsigned DELTA_W    = 5;
    localparam int unsigned WEIGHT_W   = 16;
    localparam int unsigned ELAPSED_W  = 16;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned LCOUNT_W   = 4;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Largest count that the pending count field can show.
    localparam int unsigned COUNT_MAX = 31;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SET  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic                 RAMP_ENABLE_RST = 1'b1;
    localparam logic [RATE_W-1:0]   RAMP_RATE_RST   = 16'd2147;
    localparam logic [LCOUNT_W-1:0] LAYER_COUNT_RST = 4'd8;

    // One entry of the pending list.
    typedef struct packed {
        logic [LAYER_W-1:0]         layer;
        logic [DELTA_W-1:0]         delta;
        logic signed [WEIGHT_W-1:0] target;
    } t_pend_entry;

    // Result of one slew step.
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       reached;
    } t_slew_res;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_ENT,
        S_UPD,
        S_RDW,
        S_FIN
    } t_state;

endpackage

/* rtl/multi_channel_weight_slew_unit.sv */
// Multi-channel weight slew unit: a store of blend weights with slew-rate limited updates.
// Top level: configuration registers, sequencer and output register.
// Depends on mslw_pkg, mslw_wstore, mslw_plist and mslw_slew_alu.
//
// Usage. Items arrive on the input channel (i_in_valid / o_in_stall) and each gives exactly
// one result on the output channel (o_out_valid / i_out_stall). A transfer takes place on a
// rising edge with valid high and stall low. A set item either writes a weight at once or,
// with ramping enabled, queues it on the pending list (dropped if full); a tick item walks
// the pending list and moves every queued weight toward its target; a read item returns one stored weight.
// The block works on one item at a time: o_in_stall is high from the transfer of an item
// until its result has been loaded into the output register.
// After the transfer, a set or an unknown request passes through S_DISP and S_FIN, a read
// through S_DISP, S_RDW (in range only) and S_FIN, and a tick through S_DISP, then S_ENT and
// S_UPD once per pending entry, then S_FIN. The walk is bound by the pending list memory and
// the weight store, each read once per entry through a registered port, and by the one slew unit.
// The output register decouples the two sides: a result waiting under i_out_stall does not
// keep the next item from being taken, but the following result waits until it is free.
// Reset (synchronous, active low) returns the configuration registers to their defaults,
// empties the pending list and makes every stored weight read as zero at once.
// Configuration writes (i_cfg_we) may be made at any time but are meant for idle periods.
module multi_channel_weight_slew_unit
    import mslw_pkg::*;
#(
    parameter int unsigned LAYERS        = LAYERS_DEF,
    parameter int unsigned DELTAS        = DELTAS_DEF,
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [REQ_W-1:0]             i_req_type,
    input  logic [LAYER_W-1:0]           i_layer,
    input  logic [DELTA_W-1:0]           i_delta_index,
    input  logic signed [WEIGHT_W-1:0]   i_target_weight,
    input  logic [ELAPSED_W-1:0]         i_elapsed_us,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [WEIGHT_W-1:0]   o_read_weight,
    output logic [COUNT_W-1:0]           o_pending_count,
    output logic                         o_dropped
);

    // Only layers and deltas that the index fields can reach need storage.
    localparam int unsigned LAYERS_E    = (LAYERS < (1 << LAYER_W)) ? LAYERS : (1 << LAYER_W);
    localparam int unsigned DELTAS_E    = (DELTAS < (1 << DELTA_W)) ? DELTAS : (1 << DELTA_W);
    localparam int unsigned STORE_DEPTH = LAYERS_E * DELTAS_E;
    localparam int unsigned SW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned PW          = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned CW          = $clog2(PENDING_DEPTH + 1);

    // Configuration registers.
    logic                  r_ramp_enable;
    logic [RATE_W-1:0]     r_ramp_rate;
    logic [LCOUNT_W-1:0]   r_layer_count;

    // Captured item.
    logic [REQ_W-1:0]           r_req;
    logic [LAYER_W-1:0]         r_layer;
    logic [DELTA_W-1:0]         r_delta;
    logic signed [WEIGHT_W-1:0] r_target;
    logic [ELAPSED_W-1:0]       r_elapsed;

    // Sequencer and walk state.
    t_state                     r_state;
    t_state                     n_state;
    logic [CW-1:0]              r_used;
    logic [CW-1:0]              r_rd;
    logic [CW-1:0]              r_wr;
    logic [RATE_W-1:0]          r_step;
    t_pend_entry                r_ent;
    logic signed [WEIGHT_W-1:0] r_res_w;
    logic                       r_res_drop;

    // Output register.
    logic                       r_out_valid;
    logic signed [WEIGHT_W-1:0] r_out_w;
    logic [COUNT_W-1:0]         r_out_cnt;
    logic                       r_out_drop;

    // Memory ports.
    logic                       w_ws_we;
    logic [SW-1:0]              w_ws_waddr;
    logic signed [WEIGHT_W-1:0] w_ws_wdata;
    logic                       w_ws_re;
    logic [SW-1:0]              w_ws_raddr;
    logic signed [WEIGHT_W-1:0] w_ws_rdata;
    logic                       w_pl_we;
    logic [PW-1:0]              w_pl_waddr;
    t_pend_entry                w_pl_wdata;
    logic                       w_pl_re;
    logic [PW-1:0]              w_pl_raddr;
    t_pend_entry                w_pl_rdata;

    // Derived signals.
    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_inside;
    logic                       w_set_ok;
    logic                       w_full;
    logic                       w_more;
    logic                       w_last;
    logic [SW-1:0]              w_item_idx;
    logic [SW-1:0]              w_pend_idx;
    logic [SW-1:0]              w_ent_idx;
    logic [2*RATE_W-1:0]        w_prod;
    logic [CW-1:0]              w_rd_inc;
    logic [COUNT_W-1:0]         w_cnt_sat;
    t_slew_res                  w_slew;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_inside   = (32'(r_layer) < LAYERS) && (32'(r_delta) < DELTAS);
    // The layer limit is the smaller of the register and LAYERS; w_inside covers the latter.
    assign w_set_ok   = w_inside && ({1'b0, r_layer} < r_layer_count);
    assign w_full     = !(32'(r_used) < PENDING_DEPTH);
    assign w_rd_inc   = r_rd + 1'b1;
    assign w_more     = w_rd_inc < r_used;
    assign w_last     = !w_more;

    assign w_item_idx = SW'(32'(r_layer) * DELTAS_E + 32'(r_delta));
    assign w_pend_idx = SW'(32'(w_pl_rdata.layer) * DELTAS_E + 32'(w_pl_rdata.delta));
    assign w_ent_idx  = SW'(32'(r_ent.layer) * DELTAS_E + 32'(r_ent.delta));

    assign w_prod     = {{RATE_W{1'b0}}, r_elapsed} * {{ELAPSED_W{1'b0}}, r_ramp_rate};
    assign w_cnt_sat  = (32'(r_used) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(r_used);

    mslw_wstore #(
        .DEPTH (STORE_DEPTH),
        .AW    (SW)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_ws_we),
        .i_waddr (w_ws_waddr),
        .i_wdata (w_ws_wdata),
        .i_re    (w_ws_re),
        .i_raddr (w_ws_raddr),
        .o_rdata (w_ws_rdata)
    );

    mslw_plist #(
        .DEPTH (PENDING_DEPTH),
        .AW    (PW)
    ) u_plist (
        .i_clk   (i_clk),
        .i_we    (w_pl_we),
        .i_waddr (w_pl_waddr),
        .i_wdata (w_pl_wdata),
        .i_re    (w_pl_re),
        .i_raddr (w_pl_raddr),
        .o_rdata (w_pl_rdata)
    );

    mslw_slew_alu u_alu (
        .i_cur    (w_ws_rdata),
        .i_target (r_ent.target),
        .i_step   (r_step),
        .o_res    (w_slew)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_enable <= RAMP_ENABLE_RST;
            r_ramp_rate   <= RAMP_RATE_RST;
            r_layer_count <= LAYER_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAMP_ENABLE: r_ramp_enable <= i_cfg_data[0];
                CFG_RAMP_RATE:   r_ramp_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[LCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_req)
                    REQ_TICK: n_state = (r_used == '0) ? S_FIN : S_ENT;
                    REQ_READ: n_state = w_inside ? S_RDW : S_FIN;
                    default:  n_state = S_FIN;
                endcase
            end
            S_ENT: n_state = S_UPD;
            S_UPD: n_state = w_last ? S_FIN : S_ENT;
            S_RDW: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory strobes and stall.
    always_comb begin
        o_in_stall = 1'b1;
        w_ws_we    = 1'b0;
        w_ws_waddr = w_item_idx;
        w_ws_wdata = r_target;
        w_ws_re    = 1'b0;
        w_ws_raddr = w_item_idx;
        w_pl_we    = 1'b0;
        w_pl_waddr = r_used[PW-1:0];
        w_pl_wdata = '{layer: r_layer, delta: r_delta, target: r_target};
        w_pl_re    = 1'b0;
        w_pl_raddr = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_DISP: begin
                case (r_req)
                    REQ_SET: begin
                        if (w_set_ok && r_ramp_enable && !w_full) begin
                            w_pl_we = 1'b1;
                        end
                        if (w_set_ok && !r_ramp_enable) begin
                            w_ws_we = 1'b1;
                        end
                    end
                    REQ_TICK: begin
                        w_pl_re = (r_used != '0);
                    end
                    REQ_READ: begin
                        w_ws_re = w_inside;
                    end
                    default: begin
                    end
                endcase
            end
            S_ENT: begin
                // Fetch the weight of this entry and, in parallel, the next entry.
                w_ws_re    = 1'b1;
                w_ws_raddr = w_pend_idx;
                w_pl_re    = w_more;
                w_pl_raddr = w_rd_inc[PW-1:0];
            end
            S_UPD: begin
                w_ws_we    = 1'b1;
                w_ws_waddr = w_ent_idx;
                w_ws_wdata = w_slew.weight;
                // Entries still short of their target close up in order.
                w_pl_we    = !w_slew.reached;
                w_pl_waddr = r_wr[PW-1:0];
                w_pl_wdata = r_ent;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DISP && r_req == REQ_SET && w_set_ok && r_ramp_enable && !w_full) begin
                r_used <= r_used + 1'b1;
            end
            if (r_state == S_UPD && w_last) begin
                r_used <= w_slew.reached ? r_wr : r_wr + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_req_type;
            r_layer   <= i_layer;
            r_delta   <= i_delta_index;
            r_target  <= i_target_weight;
            r_elapsed <= i_elapsed_us;
        end
        case (r_state)
            S_DISP: begin
                r_res_w    <= '0;
                r_res_drop <= (r_req == REQ_SET) && w_set_ok && r_ramp_enable && w_full;
                r_step     <= w_prod[2*RATE_W-1:RATE_W];
                r_rd       <= '0;
                r_wr       <= '0;
            end
            S_ENT: begin
                r_ent <= w_pl_rdata;
            end
            S_UPD: begin
                r_rd <= w_rd_inc;
                if (!w_slew.reached) begin
                    r_wr <= r_wr + 1'b1;
                end
            end
            S_RDW: begin
                r_res_w <= w_ws_rdata;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_out_w    <= r_res_w;
            r_out_cnt  <= w_cnt_sat;
            r_out_drop <= r_res_drop;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_weight   = r_out_w;
    assign o_pending_count = r_out_cnt;
    assign o_dropped       = r_out_drop;

endmodule

/* rtl/mslw_wstore.sv */
// Weight store: one signed weight per (layer, delta) with a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on mslw_pkg.
module mslw_wstore
    import mslw_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic signed [WEIGHT_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic signed [WEIGHT_W-1:0] o_rdata
);

    logic signed [WEIGHT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic signed [WEIGHT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mslw_plist.sv */
// Pending list memory: one write port and one registered read port.
// Contents are undefined until written; the fill count lives in the sequencer.
// Depends on mslw_pkg.
module mslw_plist
    import mslw_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pend_entry   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_pend_entry   o_rdata
);

    t_pend_entry r_mem [DEPTH];
    t_pend_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mslw_slew_alu.sv */
// Shared slew unit: moves a weight one step toward its target and clamps there.
// One adder plus the compares for direction, equality and overshoot; used once per pending entry during a tick.
// Depends on mslw_pkg.
module mslw_slew_alu
    import mslw_pkg::*;
(
    input  logic signed [WEIGHT_W-1:0] i_cur,
    input  logic signed [WEIGHT_W-1:0] i_target,
    input  logic [RATE_W-1:0]          i_step,
    output t_slew_res                  o_res
);

    localparam int unsigned EXT_W = WEIGHT_W + 2;

    logic                    w_down;
    logic                    w_equal;
    logic signed [EXT_W-1:0] w_cur;
    logic signed [EXT_W-1:0] w_tgt;
    logic signed [EXT_W-1:0] w_step;
    logic signed [EXT_W-1:0] w_sum;
    logic                    w_over;

    always_comb begin
        w_down  = i_target < i_cur;
        w_equal = i_target == i_cur;
        w_cur   = EXT_W'(i_cur);
        w_tgt   = EXT_W'(i_target);
        w_step  = $signed({2'b00, i_step});
        // A single adder serves both directions.
        w_sum   = w_cur + (w_down ? -w_step : w_step);
        w_over  = w_down ? (w_sum <= w_tgt) : (w_sum >= w_tgt);

        if (w_equal) begin
            o_res.weight = i_cur;
        end else if (w_over) begin
            o_res.weight = i_target;
        end else begin
            o_res.weight = w_sum[WEIGHT_W-1:0];
        end
        o_res.reached = w_equal || w_over;
    end

endmodule

/* bench/multi_channel_weight_slew_unit_tb.sv */
// Self-checking testbench for multi_channel_weight_slew_unit: directed and random
// set/tick/read transfers checked against a cycle-free model of the weight store.
// Depends on mslw_pkg and the RTL of the unit; needs nothing else.
`timescale 1ns / 1ps

module multi_channel_weight_slew_unit_tb;
    import mslw_pkg::*;

    // Request code with no meaning to the unit; it must change nothing.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam int STORE_SIZE  = LAYERS_DEF * DELTAS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [REQ_W-1:0]           req;
        logic [LAYER_W-1:0]         layer;
        logic [DELTA_W-1:0]         delta;
        logic signed [WEIGHT_W-1:0] target;
        logic [ELAPSED_W-1:0]       elapsed;
    } t_weight_request;

    typedef struct {
        logic signed [WEIGHT_W-1:0] weight;
        logic [COUNT_W-1:0]         count;
        logic                       dropped;
    } t_weight_result;

    // Ports of the unit.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [REQ_W-1:0]           i_req_type = '0;
    logic [LAYER_W-1:0]         i_layer = '0;
    logic [DELTA_W-1:0]         i_delta_index = '0;
    logic signed [WEIGHT_W-1:0] i_target_weight = '0;
    logic [ELAPSED_W-1:0]       i_elapsed_us = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [WEIGHT_W-1:0] o_read_weight;
    logic [COUNT_W-1:0]         o_pending_count;
    logic                       o_dropped;

    // Model of the unit: weights, ramp list and registers.
    logic signed [WEIGHT_W-1:0] mdl_weight [STORE_SIZE];
    t_pend_entry                mdl_ramp [PENDING_DEPTH_DEF];
    int unsigned                mdl_ramp_used = 0;
    logic                       cfg_ramp_en = RAMP_ENABLE_RST;
    logic [RATE_W-1:0]          cfg_rate = RAMP_RATE_RST;
    logic [LCOUNT_W-1:0]        cfg_layers = LAYER_COUNT_RST;

    t_weight_request request_q [$];
    t_weight_result  result_due_q [$];
    t_weight_request offered;
    bit              offer_accepted = 1'b0;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int              rx_hold_req = 0;
    int              rx_hold_done = 0;
    int              rx_hold_left = 0;
    int              mismatch_count = 0;
    int              cycle_count = 0;

    multi_channel_weight_slew_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_layer         (i_layer),
        .i_delta_index   (i_delta_index),
        .i_target_weight (i_target_weight),
        .i_elapsed_us    (i_elapsed_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_weight   (o_read_weight),
        .o_pending_count (o_pending_count),
        .o_dropped       (o_dropped)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Applies one accepted request to the model and returns the result that it owes.
    function automatic t_weight_result apply_weight_request(t_weight_request rq);
        t_weight_result res;
        int             lim;
        int             step;
        int             cur;
        int             tgt;
        int unsigned    prod;
        int unsigned    wr;
        int unsigned    idx;
        t_pend_entry    ent;
        res.weight  = '0;
        res.dropped = 1'b0;
        case (rq.req)
            REQ_SET: begin
                lim = (cfg_layers < LAYERS_DEF) ? int'(cfg_layers) : LAYERS_DEF;
                if (int'(rq.layer) < lim) begin
                    if (cfg_ramp_en) begin
                        if (mdl_ramp_used < PENDING_DEPTH_DEF) begin
                            mdl_ramp[mdl_ramp_used] = '{rq.layer, rq.delta, rq.target};
                            mdl_ramp_used++;
                        end else begin
                            res.dropped = 1'b1;
                        end
                    end else begin
                        mdl_weight[{rq.layer, rq.delta}] = rq.target;
                    end
                end
            end
            REQ_TICK: begin
                // The product of two 16-bit values always fits in 32 bits.
                prod = 32'(rq.elapsed) * 32'(cfg_rate);
                step = int'(prod >> 16);
                wr = 0;
                for (int unsigned rd = 0; rd < mdl_ramp_used; rd++) begin
                    ent = mdl_ramp[rd];
                    idx = {ent.layer, ent.delta};
                    cur = mdl_weight[idx];
                    tgt = ent.target;
                    if (tgt < cur) begin
                        cur -= step;
                        if (cur <= tgt) cur = tgt;
                    end else if (tgt > cur) begin
                        cur += step;
                        if (cur >= tgt) cur = tgt;
                    end
                    mdl_weight[idx] = cur[WEIGHT_W-1:0];
                    // Entries still short of their target close up in order.
                    if (cur != tgt) begin
                        mdl_ramp[wr] = ent;
                        wr++;
                    end
                end
                mdl_ramp_used = wr;
            end
            REQ_READ: res.weight = mdl_weight[{rq.layer, rq.delta}];
            default: ;
        endcase
        res.count = COUNT_W'(mdl_ramp_used);
        return res;
    endfunction

    // Random request. Most addresses fall on a few hot weights so that ramps overlap,
    // duplicates arise and reads see weights part-way to their targets.
    function automatic t_weight_request rand_request();
        t_weight_request r;
        int              pick;
        int              tmp;
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.req = REQ_SET;
        else if (pick < 70) r.req = REQ_TICK;
        else if (pick < 95) r.req = REQ_READ;
        else                r.req = REQ_UNKNOWN;
        if ($urandom_range(0, 99) < 70) begin
            r.layer = LAYER_W'($urandom_range(0, 1));
            r.delta = DELTA_W'($urandom_range(0, 3));
        end else begin
            r.layer = LAYER_W'($urandom);
            r.delta = DELTA_W'($urandom);
        end
        case ($urandom_range(0, 5))
            0: r.target = 16'sh7FFF;
            1: r.target = 16'sh8000;
            2: begin
                tmp = int'($urandom_range(0, 400)) - 200;
                r.target = tmp[WEIGHT_W-1:0];
            end
            default: r.target = WEIGHT_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: r.elapsed = '0;
            1: r.elapsed = '1;
            2, 3: r.elapsed = ELAPSED_W'($urandom_range(1, 200));
            default: r.elapsed = ELAPSED_W'($urandom);
        endcase
        return r;
    endfunction

    task automatic push_request(input logic [REQ_W-1:0] req, input int layer,
                                input int delta, input int target, input int elapsed);
        t_weight_request r;
        r.req     = req;
        r.layer   = LAYER_W'(layer);
        r.delta   = DELTA_W'(delta);
        r.target  = WEIGHT_W'(target);
        r.elapsed = ELAPSED_W'(elapsed);
        request_q.push_back(r);
    endtask

    // Register write; the model follows once the write edge has passed.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RAMP_ENABLE: cfg_ramp_en = val[0];
            CFG_RAMP_RATE:   cfg_rate = val[RATE_W-1:0];
            CFG_LAYER_COUNT: cfg_layers = val[LCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Returns once every queued request has been transferred and every result has come.
    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || result_due_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int ramp_en, input int rate, input int layers,
                             input int tx_pct, input int rx_pct, input int n_items,
                             input bit long_hold);
        write_reg(CFG_RAMP_ENABLE, CFG_DATA_W'(ramp_en));
        write_reg(CFG_RAMP_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_LAYER_COUNT, CFG_DATA_W'(layers));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < n_items; n++)
            request_q.push_back(rand_request());
        // The receiver holds off while requests keep coming, so the unit backs up.
        if (long_hold) rx_hold_req++;
        wait_drained();
    endtask

    // Driver: a stalled request is held unchanged; otherwise the next one may be offered.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || offer_accepted) begin
            offer_accepted = 1'b0;
            if (request_q.size() == 0 || $urandom_range(0, 99) < tx_idle_pct) begin
                i_in_valid <= 1'b0;
            end else begin
                offered = request_q.pop_front();
                i_in_valid      <= 1'b1;
                i_req_type      <= offered.req;
                i_layer         <= offered.layer;
                i_delta_index   <= offered.delta;
                i_target_weight <= offered.target;
                i_elapsed_us    <= offered.elapsed;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here whenever one is asked.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_hold_req != rx_hold_done) begin
            rx_hold_done++;
            rx_hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Monitor: checks each result transfer, then predicts for each request transfer.
    always @(posedge i_clk) begin : monitor
        t_weight_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_due_q.size() == 0) begin
                    $error("result transfer with no result due");
                    mismatch_count++;
                end else begin
                    want = result_due_q.pop_front();
                    if (o_read_weight !== want.weight) begin
                        $error("read_weight: expected %0d, got %0d", want.weight,
                               o_read_weight);
                        mismatch_count++;
                    end
                    if (o_pending_count !== want.count) begin
                        $error("pending_count: expected %0d, got %0d", want.count,
                               o_pending_count);
                        mismatch_count++;
                    end
                    if (o_dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, o_dropped);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                result_due_q.push_back(apply_weight_request(offered));
                offer_accepted = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < STORE_SIZE; k++) mdl_weight[k] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration: ramping on, default rate, all layers.
        tx_idle_pct = 11;
        rx_idle_pct = 53;
        push_request(REQ_READ, 0, 0, 0, 0);
        push_request(REQ_SET, 0, 0, 32767, 0);
        push_request(REQ_SET, 7, 31, -32768, 0);
        // A second ramp on the same weight; both entries step it.
        push_request(REQ_SET, 0, 0, 100, 0);
        push_request(REQ_UNKNOWN, 7, 31, -1, 65535);
        push_request(REQ_TICK, 5, 17, 1234, 65535);
        push_request(REQ_READ, 0, 0, 0, 0);
        push_request(REQ_READ, 7, 31, 0, 0);
        push_request(REQ_TICK, 0, 0, 0, 0);
        // A ramp already at its target goes on the next tick, even with a zero step.
        push_request(REQ_SET, 3, 9, 0, 0);
        push_request(REQ_TICK, 0, 0, 0, 0);
        // Fill the list to the brim; the last set finds it full and is dropped.
        for (int k = 0; k < 15; k++)
            push_request(REQ_SET, k % 8, k + 4, 1000 + k, 0);
        wait_drained();

        // Random part: sender idles lightly and receiver heavily, then the reverse,
        // then neither. Settings cover both ramp modes and the extremes of rate and count.
        run_phase(1, 65535, 8, 11, 53, 120, 1'b0);
        run_phase(0, 0, 1, 11, 53, 80, 1'b0);
        run_phase(1, 0, 0, 53, 11, 40, 1'b0);
        run_phase(1, RAMP_RATE_RST, 15, 53, 11, 150, 1'b1);
        run_phase(1, 300, 5, 0, 0, 120, 1'b0);
        run_phase(0, 65535, 8, 0, 0, 60, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (result_due_q.size() != 0) begin
            $error("%0d results never arrived", result_due_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
